// ===== hdl/fbcrc_pkg.sv =====
// Shared types and constants for the frame buffer with region CRC.
package fbcrc_pkg;

    localparam logic [2:0] KIND_WRITE = 3'd0;
    localparam logic [2:0] KIND_FILL  = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_CRC   = 3'd3;
    localparam logic [2:0] KIND_COUNT = 3'd4;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam int unsigned CMD_W = 3 + 12 + 12 + 16 + 12 + 12;

    // One classified command word passed from the front end to the back end.
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic [15:0]        pixel_color;
        logic [11:0]        region_width;
        logic [11:0]        region_height;
    } cmd_t;

    // One CRC byte step, eight bit iterations on a 32-bit value.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/framebuffer_with_region_crc.sv =====
// Top level of the frame buffer with region CRC.
// Usage:
// Commands arrive on the s_axis channel, one word each: the kind on tuser,
// position, color and region size on tdata. Results leave on m_axis, one
// word for each read, region CRC or count; writes and fills give none.
// Unknown kinds are dropped.
// A two-entry queue separates the accepting front end from the back end,
// which owns the pixel store with one write port and one read port.
// A pixel write is done in the back end as it is taken, so writes stream
// at one per cycle while the back end is idle. Fill and count walk the
// active canvas at one pixel per cycle; a CRC walks the clipped region
// at one pixel per cycle, the rate set by the one store read port.
// Result words are held in an output register.
// After reset the back end clears the store, one entry per cycle, before
// it takes commands; the queue still accepts up to two words. If m_axis
// stalls, the back end waits with the finished result and input backs
// up through the queue.
// canvas_width and canvas_height sit at APB byte addresses 0 and 4.
module framebuffer_with_region_crc #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pos_x, pos_y, pixel_color, region_width, region_height
    input  logic [63:0] s_axis_tdata,
    // kind
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value
    output logic [31:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    logic [8:0] width_reg, height_reg;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == ADDR_WIDTH)
                width_reg <= pwdata[8:0];
            else if (paddr == ADDR_HEIGHT)
                height_reg <= pwdata[8:0];
        end
    end
    assign prdata = (paddr == ADDR_WIDTH) ? {23'd0, width_reg}
                  : (paddr == ADDR_HEIGHT) ? {23'd0, height_reg} : 32'd0;

    // Unpack the input word.
    fbcrc_pkg::cmd_t in_cmd, q_cmd;
    assign in_cmd.kind          = s_axis_tuser;
    assign in_cmd.pos_x         = s_axis_tdata[11:0];
    assign in_cmd.pos_y         = s_axis_tdata[23:12];
    assign in_cmd.pixel_color   = s_axis_tdata[39:24];
    assign in_cmd.region_width  = s_axis_tdata[51:40];
    assign in_cmd.region_height = s_axis_tdata[63:52];

    logic q_valid, q_ready;

    fbcrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_cmd   (in_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    fbcrc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .canvas_width  (width_reg),
        .canvas_height (height_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .res_valid     (m_axis_tvalid),
        .res_ready     (m_axis_tready),
        .res_value     (m_axis_tdata)
    );

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A full queue that the back end does not drain keeps its words.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready && !s_axis_tready |=> q_valid)
        else $error("queue lost a word");

endmodule

// ===== hdl/fbcrc_front.sv =====
// Front end: accepts words, drops unknown kinds and queues commands.
module fbcrc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbcrc_pkg::cmd_t     in_cmd,
    output logic                q_valid,
    input  logic                q_ready,
    output fbcrc_pkg::cmd_t     q_cmd
);

    // Two-entry queue.
    fbcrc_pkg::cmd_t mem_reg [2];
    logic            wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop, known;

    assign known    = (in_cmd.kind <= fbcrc_pkg::KIND_COUNT);
    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && known;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

endmodule

// ===== hdl/fbcrc_back.sv =====
// Back end: pixel store, clearing pass, writes, reads, and fill, CRC and count walks.
module fbcrc_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [8:0]      canvas_width,
    input  logic [8:0]      canvas_height,
    input  logic            q_valid,
    output logic            q_ready,
    input  fbcrc_pkg::cmd_t q_cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output logic [31:0]     res_value
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [15:0] store [DEPTH];

    logic [2:0]  state_reg, state_next;
    logic [2:0]  kind_reg;
    logic [15:0] color_reg;
    logic [CW-1:0] w_eff, c0_reg, c1_reg, c_reg;
    logic [RW-1:0] h_eff, r1_reg, r_reg;
    logic [AW:0]   addr_reg, rowbase_reg;
    logic [AW:0]   total_reg;
    logic        rd_pend_reg;
    logic [15:0] rd_data_reg;
    logic [31:0] acc_reg;
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [AW:0] clr_reg;

    assign w_eff = (32'(canvas_width) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(canvas_width);
    assign h_eff = (32'(canvas_height) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT)
                                                           : RW'(canvas_height);

    // Clipping of the incoming command, all at 14 bits signed.
    logic signed [13:0] sx, sy, sw, sh, x1, y1, c0s, r0s, c1s, r1s;
    logic on_canvas, take, crc_nonempty, canvas_nonempty;
    always_comb
    begin
        sx  = 14'(q_cmd.pos_x);
        sy  = 14'(q_cmd.pos_y);
        sw  = 14'($signed({2'b00, w_eff}));
        sh  = 14'($signed({2'b00, h_eff}));
        x1  = sx + $signed({2'b00, q_cmd.region_width});
        y1  = sy + $signed({2'b00, q_cmd.region_height});
        c0s = (sx < 0) ? 14'sd0 : sx;
        r0s = (sy < 0) ? 14'sd0 : sy;
        c1s = (x1 < sw) ? x1 : sw;
        r1s = (y1 < sh) ? y1 : sh;
        on_canvas = (sx >= 0) && (sy >= 0) && (sx < sw) && (sy < sh);
        crc_nonempty = (c0s < c1s) && (r0s < r1s);
        canvas_nonempty = (w_eff != '0) && (h_eff != '0);
    end

    // Row base of the first pixel; one multiply, registered.
    logic [AW:0] base_addr;
    assign base_addr = (AW+1)'(r0s[RW-1:0]) * (AW+1)'(w_eff) + (AW+1)'(c0s[CW-1:0]);

    assign take    = (state_reg == ST_IDLE) && q_valid;
    assign q_ready = (state_reg == ST_IDLE);

    // Walk: issue an address per cycle, consume its data in the next cycle.
    logic        walk_last, issue;
    assign issue = (state_reg == ST_WALK);
    assign walk_last = (kind_reg == fbcrc_pkg::KIND_CRC)
        ? ((c_reg + 1'b1 == c1_reg) && (r_reg + 1'b1 == r1_reg))
        : (addr_reg + 1'b1 == total_reg);

    logic [31:0] acc_upd;
    always_comb
    begin
        acc_upd = acc_reg;
        if (kind_reg == fbcrc_pkg::KIND_CRC)
            acc_upd = fbcrc_pkg::crc_byte(fbcrc_pkg::crc_byte(acc_reg, rd_data_reg[7:0]),
                                          rd_data_reg[15:8]);
        else if (kind_reg == fbcrc_pkg::KIND_COUNT)
            acc_upd = acc_reg + {31'd0, rd_data_reg != color_reg};
    end

    // Next state, including the dispatch of a newly taken command.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.kind == fbcrc_pkg::KIND_READ)
                        state_next = ST_DRAIN;
                    else if (q_cmd.kind == fbcrc_pkg::KIND_CRC)
                        state_next = crc_nonempty ? ST_WALK : ST_OUT;
                    else if (q_cmd.kind == fbcrc_pkg::KIND_FILL
                             || q_cmd.kind == fbcrc_pkg::KIND_COUNT)
                        state_next = canvas_nonempty ? ST_WALK : ST_OUT;
                end
            end
            ST_WALK:  if (walk_last) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_pend_reg) state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            rd_pend_reg <= (issue && (kind_reg != fbcrc_pkg::KIND_FILL))
                        || (take && q_cmd.kind == fbcrc_pkg::KIND_READ);
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                out_valid_reg <= (kind_reg != fbcrc_pkg::KIND_FILL);
            else if (res_valid && res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= (q_cmd.kind == fbcrc_pkg::KIND_READ && !on_canvas)
                       ? fbcrc_pkg::KIND_WRITE : q_cmd.kind;
            color_reg <= q_cmd.pixel_color;
            c0_reg    <= c0s[CW-1:0];
            c1_reg    <= c1s[CW-1:0];
            c_reg     <= c0s[CW-1:0];
            r1_reg    <= r1s[RW-1:0];
            r_reg     <= r0s[RW-1:0];
            total_reg <= (AW+1)'(w_eff) * (AW+1)'(h_eff);
            if (q_cmd.kind == fbcrc_pkg::KIND_CRC)
            begin
                addr_reg    <= base_addr;
                rowbase_reg <= base_addr;
            end
            else
            begin
                addr_reg <= (q_cmd.kind == fbcrc_pkg::KIND_READ)
                    ? (AW+1)'(sy[RW-1:0]) * (AW+1)'(w_eff) + (AW+1)'(sx[CW-1:0]) : '0;
            end
        end
        else if (issue)
        begin
            if (kind_reg == fbcrc_pkg::KIND_CRC && c_reg + 1'b1 == c1_reg)
            begin
                c_reg       <= c0_reg;
                r_reg       <= r_reg + 1'b1;
                rowbase_reg <= rowbase_reg + (AW+1)'(w_eff);
                addr_reg    <= rowbase_reg + (AW+1)'(w_eff);
            end
            else
            begin
                c_reg    <= c_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
        end
        // Accumulator: seeded on take, fed in the cycle after each read,
        // the last read included while draining.
        if (take)
            acc_reg <= (q_cmd.kind == fbcrc_pkg::KIND_CRC) ? fbcrc_pkg::CRC_INIT : '0;
        else if (rd_pend_reg)
            acc_reg <= acc_upd;
        else if (state_reg == ST_DRAIN)
            acc_reg <= (kind_reg == fbcrc_pkg::KIND_READ) ? {16'd0, rd_data_reg}
                     : (kind_reg == fbcrc_pkg::KIND_WRITE) ? 32'd0 : acc_reg;
        if (state_reg == ST_OUT && state_next == ST_IDLE)
            out_value_reg <= (kind_reg == fbcrc_pkg::KIND_CRC) ? ~acc_reg : acc_reg;
    end

    // Store: one write and one registered read per cycle.
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0] wr_data;
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg[AW-1:0];
        wr_data = color_reg;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = 16'h0000;
        end
        else if (issue && kind_reg == fbcrc_pkg::KIND_FILL)
            wr_en = 1'b1;
        else if (take && q_cmd.kind == fbcrc_pkg::KIND_WRITE && on_canvas)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(sy[RW-1:0]) * AW'(w_eff) + AW'(sx[CW-1:0]);
            wr_data = q_cmd.pixel_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= wr_data;
        rd_data_reg <= store[addr_reg[AW-1:0]];
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;

endmodule
